// ===== design/frame_checksum_checker_top_macros.svh =====
// Assertion macros shared by the frame checksum checker RTL.
`ifndef FRAME_CHECKSUM_CHECKER_TOP_MACROS_SVH
`define FRAME_CHECKSUM_CHECKER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define FCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define FCC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/fcc_pkg.sv =====
// Package for the frame checksum checker: mode codes, widths and helper functions.
package fcc_pkg;

  localparam int unsigned ModeW  = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [ModeW-1:0] MODE_NONE   = 3'd0;
  localparam logic [ModeW-1:0] MODE_CRC8   = 3'd1;
  localparam logic [ModeW-1:0] MODE_XOR    = 3'd2;
  localparam logic [ModeW-1:0] MODE_CCITT  = 3'd3;
  localparam logic [ModeW-1:0] MODE_MODBUS = 3'd4;
  localparam logic [ModeW-1:0] MODE_CRC32  = 3'd5;

  localparam logic [CfgIdxW-1:0] REG_CHECK_MODE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_CRC8_POLY  = 2'd1;

  localparam logic [7:0]  CRC8_POLY_RST = 8'h07;
  localparam logic [15:0] CCITT_POLY    = 16'h1021;
  localparam logic [15:0] MODBUS_POLY   = 16'hA001;
  localparam logic [31:0] CRC32_POLY    = 32'hEDB88320;
  localparam logic [31:0] CRC32_XOROUT  = 32'hFFFFFFFF;

  // Inputs of one byte update of the running check.
  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [7:0]       poly8;
    logic [31:0]      acc;
    logic [7:0]       data;
  } absorb_req_t;

  function automatic logic [2:0] trailer_len(input logic [ModeW-1:0] mode);
    case (mode)
      MODE_CRC8, MODE_XOR:      trailer_len = 3'd1;
      MODE_CCITT, MODE_MODBUS:  trailer_len = 3'd2;
      MODE_CRC32:               trailer_len = 3'd4;
      default:                  trailer_len = 3'd0;
    endcase
  endfunction

  function automatic logic [31:0] initial_check(input logic [ModeW-1:0] mode);
    case (mode)
      MODE_CCITT, MODE_MODBUS: initial_check = 32'h0000FFFF;
      MODE_CRC32:              initial_check = 32'hFFFFFFFF;
      default:                 initial_check = 32'h0;
    endcase
  endfunction

endpackage

// ===== design/fcc_byte_if.sv =====
// Channel interfaces: input bytes, check results and register writes.
interface fcc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;
  modport source (output valid, data_byte, frame_end, input ready);
  modport sink   (input valid, data_byte, frame_end, output ready);
endinterface

interface fcc_result_if;
  logic        valid;
  logic        ready;
  logic        check_passed;
  logic        frame_too_short;
  logic [31:0] computed_value;
  logic [31:0] received_value;
  modport source (output valid, check_passed, frame_too_short, computed_value,
                  received_value, input ready);
  modport sink   (input valid, check_passed, frame_too_short, computed_value,
                  received_value, output ready);
endinterface

interface fcc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [fcc_pkg::CfgIdxW-1:0]  index;
  logic [fcc_pkg::CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/fcc_absorb.sv =====
// One-byte update of the running check for every mode, unrolled over eight bits.
module fcc_absorb (
  input  fcc_pkg::absorb_req_t req_i,
  output logic [31:0]          acc_o
);

  logic [7:0]  crc8;
  logic [15:0] ccitt;
  logic [15:0] modbus;
  logic [31:0] crc32;

  always_comb begin
    crc8   = req_i.acc[7:0] ^ req_i.data;
    ccitt  = req_i.acc[15:0] ^ {req_i.data, 8'h00};
    modbus = req_i.acc[15:0] ^ {8'h00, req_i.data};
    crc32  = req_i.acc ^ {24'h0, req_i.data};
    for (int k = 0; k < 8; k++) begin
      crc8   = crc8[7] ? ({crc8[6:0], 1'b0} ^ req_i.poly8) : {crc8[6:0], 1'b0};
      ccitt  = ccitt[15] ? ({ccitt[14:0], 1'b0} ^ fcc_pkg::CCITT_POLY)
                         : {ccitt[14:0], 1'b0};
      modbus = modbus[0] ? ({1'b0, modbus[15:1]} ^ fcc_pkg::MODBUS_POLY)
                         : {1'b0, modbus[15:1]};
      crc32  = crc32[0] ? ({1'b0, crc32[31:1]} ^ fcc_pkg::CRC32_POLY)
                        : {1'b0, crc32[31:1]};
    end
  end

  always_comb begin
    case (req_i.mode)
      fcc_pkg::MODE_CRC8:   acc_o = {24'h0, crc8};
      fcc_pkg::MODE_XOR:    acc_o = {24'h0, req_i.acc[7:0] ^ req_i.data};
      fcc_pkg::MODE_CCITT:  acc_o = {16'h0, ccitt};
      fcc_pkg::MODE_MODBUS: acc_o = {16'h0, modbus};
      fcc_pkg::MODE_CRC32:  acc_o = crc32;
      default:              acc_o = req_i.acc;
    endcase
  end

endmodule

// ===== design/frame_checksum_checker_top.sv =====
// Frame checksum checker top level: input register, check update and result register.
//
// Usage:
//   in_i   takes one frame byte per transfer, frame_end high on the last byte.
//   out_o  gives one result per frame, on the transfer after its last byte.
//   cfg_i  writes check_mode (index 0) or crc8_polynomial (index 1); always
//          ready. Write only while no frame is in flight. A check_mode write
//          drops any partial frame and restarts the check.
// Path: a last byte goes through the input register, then the update and
//   result register, to out_o. Throughput: one byte per cycle unless a held
//   result stalls the input, set by the combinational CRC byte update (eight
//   bit steps unrolled) between the two registers.
// Stall: when out_o is held off, a held result blocks only the next last
//   byte; other bytes keep flowing. Input ready falls only when the input
//   register holds a last byte that cannot move into the full result register.
// Reset: mode none, CRC-8 polynomial 0x07, empty window, no result pending.
`include "frame_checksum_checker_top_macros.svh"

module frame_checksum_checker_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  fcc_byte_if.sink      in_i,
  fcc_cfg_if.sink       cfg_i,
  fcc_result_if.source  out_o
);

  logic [fcc_pkg::ModeW-1:0] mode_q;
  logic [7:0]                poly_q;

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_end_q;

  logic [31:0]    run_q, run_d;
  logic [3:0][7:0] win_q, win_d;
  logic [2:0]     cnt_q, cnt_d;

  logic        out_valid_q;
  logic        out_pass_q, out_pass_d;
  logic        out_short_q, out_short_d;
  logic [31:0] out_comp_q, out_comp_d;
  logic [31:0] out_recv_q, out_recv_d;

  logic s1_adv, in_xfer, cfg_xfer, mode_wr, out_load;
  logic [2:0]  tlen;
  logic        absorb_en;
  logic [31:0] absorbed, run_nx;
  logic [1:0]  tap_idx;
  fcc_pkg::absorb_req_t absorb_req;

  assign cfg_i.ready = 1'b1;
  assign cfg_xfer    = cfg_i.valid;
  assign mode_wr     = cfg_xfer && (cfg_i.index == fcc_pkg::REG_CHECK_MODE);

  assign s1_adv   = s1_valid_q && (!s1_end_q || !out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_load = s1_adv && s1_end_q;

  assign tlen      = fcc_pkg::trailer_len(mode_q);
  assign absorb_en = (tlen != 3'd0) && (cnt_q >= tlen);
  assign tap_idx   = 2'(tlen - 3'd1);

  assign absorb_req = '{mode: mode_q, poly8: poly_q, acc: run_q, data: win_q[tap_idx]};

  fcc_absorb u_absorb (
    .req_i (absorb_req),
    .acc_o (absorbed)
  );

  assign run_nx = absorb_en ? absorbed : run_q;

  always_comb begin
    win_d       = {win_q[2:0], s1_byte_q};
    cnt_d       = (cnt_q < 3'd4) ? cnt_q + 3'd1 : cnt_q;
    run_d       = run_nx;
    out_pass_d  = 1'b1;
    out_short_d = 1'b0;
    out_comp_d  = 32'h0;
    out_recv_d  = 32'h0;
    if (tlen != 3'd0) begin
      if (cnt_d < tlen) begin
        out_pass_d  = 1'b0;
        out_short_d = 1'b1;
      end else begin
        out_comp_d = (mode_q == fcc_pkg::MODE_CRC32) ? (run_nx ^ fcc_pkg::CRC32_XOROUT)
                                                      : run_nx;
        case (tlen)
          3'd1:    out_recv_d = {24'h0, win_d[0]};
          3'd2:    out_recv_d = {16'h0, win_d[0], win_d[1]};
          default: out_recv_d = {win_d[0], win_d[1], win_d[2], win_d[3]};
        endcase
        out_pass_d = (out_comp_d == out_recv_d);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= fcc_pkg::MODE_NONE;
      poly_q <= fcc_pkg::CRC8_POLY_RST;
    end else if (cfg_xfer) begin
      if (cfg_i.index == fcc_pkg::REG_CHECK_MODE) begin
        mode_q <= cfg_i.data[fcc_pkg::ModeW-1:0];
      end else if (cfg_i.index == fcc_pkg::REG_CRC8_POLY) begin
        poly_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_byte_q <= in_i.data_byte;
      s1_end_q  <= in_i.frame_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 32'h0;
      win_q <= '0;
      cnt_q <= 3'd0;
    end else if (mode_wr) begin
      run_q <= fcc_pkg::initial_check(cfg_i.data[fcc_pkg::ModeW-1:0]);
      win_q <= '0;
      cnt_q <= 3'd0;
    end else if (s1_adv) begin
      if (s1_end_q) begin
        run_q <= fcc_pkg::initial_check(mode_q);
        win_q <= '0;
        cnt_q <= 3'd0;
      end else begin
        run_q <= run_d;
        win_q <= win_d;
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pass_q  <= out_pass_d;
      out_short_q <= out_short_d;
      out_comp_q  <= out_comp_d;
      out_recv_q  <= out_recv_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.check_passed    = out_pass_q;
  assign out_o.frame_too_short = out_short_q;
  assign out_o.computed_value  = out_comp_q;
  assign out_o.received_value  = out_recv_q;

  `FCC_ASSERT_IMP(a_cnt_sat, 1'b1, cnt_q <= 3'd4, "byte count above four")
  `FCC_ASSERT_NXT(a_result_shown, out_load, out_valid_q, "frame end did not load a result")
  `FCC_ASSERT_NXT(a_restart, s1_adv && s1_end_q, cnt_q == 3'd0 && win_q == '0,
                  "check not restarted after frame end")
  `FCC_ASSERT_IMP(a_short_fails, out_valid_q && out_short_q, !out_pass_q,
                  "short frame reported as passed")
  `FCC_ASSERT_NXT(a_none_passes, out_load && (tlen == 3'd0), out_pass_q && !out_short_q,
                  "mode none result not passed")

endmodule
